// ===== hw/rtl/asob_pkg.sv =====
// ----------------------------------------------------------------------------
// asob_pkg
// Shared types, constants and helpers for the source-over alpha blender.
// ----------------------------------------------------------------------------
package asob_pkg;

  localparam int unsigned MAX_DIM     = 4096;
  localparam int unsigned COORD_W     = 12;
  localparam int unsigned DIM_W       = 13;
  localparam int unsigned CHAN_W      = 8;
  localparam int unsigned PROD_W      = 2 * CHAN_W;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [DIM_W-1:0]  DIM_LIMIT  = DIM_W'(MAX_DIM);
  localparam logic [CHAN_W-1:0] CHAN_FULL  = '1;

  typedef enum logic [2:0] {
    REG_ALPHA_MULT = 3'd0,
    REG_OFFSET_X   = 3'd1,
    REG_OFFSET_Y   = 3'd2,
    REG_IMG_WIDTH  = 3'd3,
    REG_IMG_HEIGHT = 3'd4
  } reg_idx_t;

  // classified request, front to back
  typedef struct packed {
    logic               write;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [CHAN_W-1:0]  sa;
    logic [CHAN_W-1:0]  src_red;
    logic [CHAN_W-1:0]  src_green;
    logic [CHAN_W-1:0]  src_blue;
    logic [CHAN_W-1:0]  dst_red;
    logic [CHAN_W-1:0]  dst_green;
    logic [CHAN_W-1:0]  dst_blue;
    logic [CHAN_W-1:0]  dst_alpha;
  } job_t;

  // exact floor(x / 255) for x <= 255 * 255
  function automatic logic [CHAN_W-1:0] div255(input logic [PROD_W-1:0] x);
    logic [PROD_W:0] t;
    t = {1'b0, x} + (PROD_W+1)'(1) + {{(CHAN_W+1){1'b0}}, x[PROD_W-1:CHAN_W]};
    return t[PROD_W-1:CHAN_W];
  endfunction

endpackage

// ===== hw/rtl/asob_front.sv =====
// ----------------------------------------------------------------------------
// asob_front
// Scales source alpha, offsets and clips the position, builds the request.
// ----------------------------------------------------------------------------
module asob_front (
  input  logic [asob_pkg::CHAN_W-1:0]  alpha_multiplier,
  input  logic [asob_pkg::DIM_W-1:0]   offset_x,
  input  logic [asob_pkg::DIM_W-1:0]   offset_y,
  input  logic [asob_pkg::DIM_W-1:0]   image_width,
  input  logic [asob_pkg::DIM_W-1:0]   image_height,
  input  logic [asob_pkg::COORD_W-1:0] src_col,
  input  logic [asob_pkg::COORD_W-1:0] src_row,
  input  logic [asob_pkg::CHAN_W-1:0]  src_red,
  input  logic [asob_pkg::CHAN_W-1:0]  src_green,
  input  logic [asob_pkg::CHAN_W-1:0]  src_blue,
  input  logic [asob_pkg::CHAN_W-1:0]  src_alpha,
  input  logic [asob_pkg::CHAN_W-1:0]  dst_red,
  input  logic [asob_pkg::CHAN_W-1:0]  dst_green,
  input  logic [asob_pkg::CHAN_W-1:0]  dst_blue,
  input  logic [asob_pkg::CHAN_W-1:0]  dst_alpha,
  output asob_pkg::job_t               job
);

  logic [asob_pkg::PROD_W-1:0] alpha_prod;
  logic [asob_pkg::CHAN_W-1:0] sa;
  logic signed [asob_pkg::DIM_W:0] tx;
  logic signed [asob_pkg::DIM_W:0] ty;
  logic [asob_pkg::DIM_W-1:0] width_eff;
  logic [asob_pkg::DIM_W-1:0] height_eff;
  logic src_ok;
  logic in_clip;

  always_comb begin
    alpha_prod = src_alpha * alpha_multiplier;
    sa         = asob_pkg::div255(alpha_prod);

    tx = $signed({offset_x[asob_pkg::DIM_W-1], offset_x}) +
         $signed({2'b00, src_col});
    ty = $signed({offset_y[asob_pkg::DIM_W-1], offset_y}) +
         $signed({2'b00, src_row});

    width_eff  = (image_width > asob_pkg::DIM_LIMIT) ? asob_pkg::DIM_LIMIT : image_width;
    height_eff = (image_height > asob_pkg::DIM_LIMIT) ? asob_pkg::DIM_LIMIT : image_height;

    src_ok = ({1'b0, src_col} < asob_pkg::DIM_LIMIT) &&
             ({1'b0, src_row} < asob_pkg::DIM_LIMIT);

    in_clip = src_ok &&
              !tx[asob_pkg::DIM_W] && (tx[asob_pkg::DIM_W-1:0] < width_eff) &&
              !ty[asob_pkg::DIM_W] && (ty[asob_pkg::DIM_W-1:0] < height_eff);

    job.write     = in_clip && (sa != '0);
    job.col       = job.write ? tx[asob_pkg::COORD_W-1:0] : '0;
    job.row       = job.write ? ty[asob_pkg::COORD_W-1:0] : '0;
    job.sa        = sa;
    job.src_red   = src_red;
    job.src_green = src_green;
    job.src_blue  = src_blue;
    job.dst_red   = dst_red;
    job.dst_green = dst_green;
    job.dst_blue  = dst_blue;
    job.dst_alpha = dst_alpha;
  end

endmodule

// ===== hw/rtl/asob_queue.sv =====
// ----------------------------------------------------------------------------
// asob_queue
// Short request queue between the front and back ends.
// ----------------------------------------------------------------------------
module asob_queue #(
  parameter int unsigned DEPTH = asob_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  asob_pkg::job_t wr_data,
  output logic           full,
  input  logic           rd_en,
  output asob_pkg::job_t rd_data,
  output logic           empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  asob_pkg::job_t mem [DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           do_wr;
  logic           do_rd;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/asob_back.sv =====
// ----------------------------------------------------------------------------
// asob_back
// Two-stage blend pipeline: channel products, then divide by 255 and select.
// ----------------------------------------------------------------------------
module asob_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  input  asob_pkg::job_t               req,
  output logic                         req_take,
  output logic                         res_valid,
  input  logic                         res_pop,
  output logic                         write_pixel,
  output logic [asob_pkg::COORD_W-1:0] target_col,
  output logic [asob_pkg::COORD_W-1:0] target_row,
  output logic [asob_pkg::CHAN_W-1:0]  out_red,
  output logic [asob_pkg::CHAN_W-1:0]  out_green,
  output logic [asob_pkg::CHAN_W-1:0]  out_blue,
  output logic [asob_pkg::CHAN_W-1:0]  out_alpha
);

  localparam int unsigned CW = asob_pkg::CHAN_W;
  localparam int unsigned PW = asob_pkg::PROD_W;

  logic [2:0][CW-1:0]     src_c;
  logic [2:0][CW-1:0]     dst_c;
  logic [2:0][PW-1:0]     mix_next;
  logic [PW-1:0]          pa_next;
  logic signed [CW:0]     diff;
  logic signed [PW+1:0]   term;
  logic [PW-1:0]          base;

  logic                   s1_valid;
  logic                   s1_write;
  logic [asob_pkg::COORD_W-1:0] s1_col;
  logic [asob_pkg::COORD_W-1:0] s1_row;
  logic [CW-1:0]          s1_sa;
  logic [2:0][PW-1:0]     s1_mix;
  logic [PW-1:0]          s1_pa;
  logic [2:0][CW-1:0]     s1_dst;
  logic [CW-1:0]          s1_dst_alpha;

  logic                   adv_out;
  logic                   ld1;

  assign adv_out  = !res_valid || res_pop;
  assign ld1      = !s1_valid || adv_out;
  assign req_take = req_valid && ld1;

  // c = dst * 255 + sa * (src - dst)
  always_comb begin
    src_c = {req.src_blue, req.src_green, req.src_red};
    dst_c = {req.dst_blue, req.dst_green, req.dst_red};
    diff  = '0;
    term  = '0;
    base  = '0;
    for (int i = 0; i < 3; i++) begin
      diff        = $signed({1'b0, src_c[i]}) - $signed({1'b0, dst_c[i]});
      term        = diff * $signed({1'b0, req.sa});
      base        = {dst_c[i], {CW{1'b0}}} - {{CW{1'b0}}, dst_c[i]};
      mix_next[i] = PW'(term + $signed({2'b00, base}));
    end
    pa_next = req.dst_alpha * (asob_pkg::CHAN_FULL - req.sa);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (ld1) begin
        s1_valid <= req_valid;
      end
      if (adv_out) begin
        res_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      s1_write     <= req.write;
      s1_col       <= req.col;
      s1_row       <= req.row;
      s1_sa        <= req.sa;
      s1_mix       <= mix_next;
      s1_pa        <= pa_next;
      s1_dst       <= dst_c;
      s1_dst_alpha <= req.dst_alpha;
    end
    if (adv_out && s1_valid) begin
      write_pixel <= s1_write;
      target_col  <= s1_col;
      target_row  <= s1_row;
      if (s1_write) begin
        out_red   <= asob_pkg::div255(s1_mix[0]);
        out_green <= asob_pkg::div255(s1_mix[1]);
        out_blue  <= asob_pkg::div255(s1_mix[2]);
        out_alpha <= s1_sa + asob_pkg::div255(s1_pa);
      end else begin
        out_red   <= s1_dst[0];
        out_green <= s1_dst[1];
        out_blue  <= s1_dst[2];
        out_alpha <= s1_dst_alpha;
      end
    end
  end

endmodule

// ===== hw/rtl/alpha_source_over_blend.sv =====
// ----------------------------------------------------------------------------
// alpha_source_over_blend
// A pushed request is held in the request queue, then in the first blend stage, and is registered at the output ports.
// Throughput: one pixel per cycle through the two-stage blend pipeline while results are popped as they appear.
// The request queue absorbs output stalls up to its depth before full rises.
// Reset: clears queue and pipeline; registers return to 255, 0, 0, 4096, 4096.
// ----------------------------------------------------------------------------
module alpha_source_over_blend #(
  parameter int unsigned QUEUE_DEPTH = asob_pkg::QUEUE_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [4:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         push,
  output logic                         full,
  input  logic [asob_pkg::COORD_W-1:0] src_col,
  input  logic [asob_pkg::COORD_W-1:0] src_row,
  input  logic [asob_pkg::CHAN_W-1:0]  src_red,
  input  logic [asob_pkg::CHAN_W-1:0]  src_green,
  input  logic [asob_pkg::CHAN_W-1:0]  src_blue,
  input  logic [asob_pkg::CHAN_W-1:0]  src_alpha,
  input  logic [asob_pkg::CHAN_W-1:0]  dst_red,
  input  logic [asob_pkg::CHAN_W-1:0]  dst_green,
  input  logic [asob_pkg::CHAN_W-1:0]  dst_blue,
  input  logic [asob_pkg::CHAN_W-1:0]  dst_alpha,
  output logic                         empty,
  input  logic                         pop,
  output logic                         write_pixel,
  output logic [asob_pkg::COORD_W-1:0] target_col,
  output logic [asob_pkg::COORD_W-1:0] target_row,
  output logic [asob_pkg::CHAN_W-1:0]  out_red,
  output logic [asob_pkg::CHAN_W-1:0]  out_green,
  output logic [asob_pkg::CHAN_W-1:0]  out_blue,
  output logic [asob_pkg::CHAN_W-1:0]  out_alpha
);

  localparam int unsigned DW = asob_pkg::DIM_W;

  logic [asob_pkg::CHAN_W-1:0] alpha_multiplier;
  logic [DW-1:0]               offset_x;
  logic [DW-1:0]               offset_y;
  logic [DW-1:0]               image_width;
  logic [DW-1:0]               image_height;

  asob_pkg::reg_idx_t reg_idx;
  logic               reg_wr;

  asob_pkg::job_t front_job;
  asob_pkg::job_t q_head;
  logic           q_full;
  logic           q_empty;
  logic           q_take;
  logic           res_valid;

  assign reg_idx = asob_pkg::reg_idx_t'(paddr[4:2]);
  assign reg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_multiplier <= asob_pkg::CHAN_FULL;
      offset_x         <= '0;
      offset_y         <= '0;
      image_width      <= asob_pkg::DIM_LIMIT;
      image_height     <= asob_pkg::DIM_LIMIT;
    end else if (reg_wr) begin
      unique case (reg_idx)
        asob_pkg::REG_ALPHA_MULT: alpha_multiplier <= pwdata[asob_pkg::CHAN_W-1:0];
        asob_pkg::REG_OFFSET_X:   offset_x         <= pwdata[DW-1:0];
        asob_pkg::REG_OFFSET_Y:   offset_y         <= pwdata[DW-1:0];
        asob_pkg::REG_IMG_WIDTH:  image_width      <= pwdata[DW-1:0];
        asob_pkg::REG_IMG_HEIGHT: image_height     <= pwdata[DW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      asob_pkg::REG_ALPHA_MULT: prdata = {24'd0, alpha_multiplier};
      asob_pkg::REG_OFFSET_X:   prdata = {{(32-DW){1'b0}}, offset_x};
      asob_pkg::REG_OFFSET_Y:   prdata = {{(32-DW){1'b0}}, offset_y};
      asob_pkg::REG_IMG_WIDTH:  prdata = {{(32-DW){1'b0}}, image_width};
      asob_pkg::REG_IMG_HEIGHT: prdata = {{(32-DW){1'b0}}, image_height};
      default:                  prdata = '0;
    endcase
  end

  asob_front u_front (
    .alpha_multiplier (alpha_multiplier),
    .offset_x         (offset_x),
    .offset_y         (offset_y),
    .image_width      (image_width),
    .image_height     (image_height),
    .src_col          (src_col),
    .src_row          (src_row),
    .src_red          (src_red),
    .src_green        (src_green),
    .src_blue         (src_blue),
    .src_alpha        (src_alpha),
    .dst_red          (dst_red),
    .dst_green        (dst_green),
    .dst_blue         (dst_blue),
    .dst_alpha        (dst_alpha),
    .job              (front_job)
  );

  asob_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_data (front_job),
    .full    (q_full),
    .rd_en   (q_take),
    .rd_data (q_head),
    .empty   (q_empty)
  );

  assign full = q_full;

  asob_back u_back (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (!q_empty),
    .req         (q_head),
    .req_take    (q_take),
    .res_valid   (res_valid),
    .res_pop     (pop),
    .write_pixel (write_pixel),
    .target_col  (target_col),
    .target_row  (target_row),
    .out_red     (out_red),
    .out_green   (out_green),
    .out_blue    (out_blue),
    .out_alpha   (out_alpha)
  );

  assign empty = !res_valid;

`ifndef NO_ASSERTIONS
  a_queue_state: assert property (@(posedge clk) disable iff (rst)
    !(q_full && q_empty))
    else $error("queue full and empty at once");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (empty && !full))
    else $error("result or full flag after reset");

  a_pass_coords: assert property (@(posedge clk) disable iff (rst)
    (!empty && !write_pixel) |-> (target_col == '0 && target_row == '0))
    else $error("pass-through result with nonzero target");

  a_take_needs_entry: assert property (@(posedge clk) disable iff (rst)
    q_take |-> !q_empty)
    else $error("back end took from empty queue");
`endif

endmodule
